// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/imra_pkg.sv =====
package imra_pkg;

	// operation codes
	localparam logic [1:0] OP_ASSIGN = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// what a cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHL,
		CELL_SHR,
		CELL_LOAD
	} cell_cmd_t;

	// compare flags a cell reports
	typedef struct packed {
		logic below;   // live and key < key_begin
		logic le_kb;   // live and key <= key_begin
		logic le_ke;   // live and key <= key_end
		logic in_span; // live and key_begin <= key <= key_end
	} cell_flag_t;

endpackage

// ===== hw/rtl/imra_cell.sv =====
module imra_cell #(
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  live,
	input  imra_pkg::cell_cmd_t   cmd,
	input  logic [KEY_BITS-1:0]   kb,
	input  logic [KEY_BITS-1:0]   ke,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [VALUE_BITS-1:0] left_val,
	input  logic [KEY_BITS-1:0]   right_key,
	input  logic [VALUE_BITS-1:0] right_val,
	input  logic [KEY_BITS-1:0]   ins_key,
	input  logic [VALUE_BITS-1:0] ins_val,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] val,
	output imra_pkg::cell_flag_t  flags
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			val_q <= '0;
		end else begin
			case (cmd)
				imra_pkg::CELL_SHL: begin
					key_q <= right_key;
					val_q <= right_val;
				end
				imra_pkg::CELL_SHR: begin
					key_q <= left_key;
					val_q <= left_val;
				end
				imra_pkg::CELL_LOAD: begin
					key_q <= ins_key;
					val_q <= ins_val;
				end
				default: begin
				end
			endcase
		end
	end

	assign key = key_q;
	assign val = val_q;

	always_comb begin
		flags.below   = live && (key_q < kb);
		flags.le_kb   = live && (key_q <= kb);
		flags.le_ke   = live && (key_q <= ke);
		flags.in_span = live && (key_q >= kb) && (key_q <= ke);
	end

endmodule

// ===== hw/rtl/interval_map_range_assign_unit.sv =====
// interval map with range assign. the table of breakpoints lives in a row of
// CAPACITY cells, sorted by key; each cell compares its key against the beat's
// keys in parallel and can take its left or right neighbor's entry each cycle.
// one beat is worked at a time: lookup, clear, an empty span or a rejected
// assign go from the evaluate state straight to the result; an accepted assign
// then drops every breakpoint inside [key_begin, key_end], the cell row dropping
// one covered breakpoint per cycle, and then inserts the breakpoints it needs
// (at most two) before its result. the result beat is held until taken and the
// next input beat is accepted the cycle after. the default value register
// is written through the cfg channel, which is always ready.
module interval_map_range_assign_unit #(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 8,
	localparam int CNT_BITS  = $clog2(CAPACITY + 1),
	localparam int IN_W      = 2 * KEY_BITS + VALUE_BITS,
	localparam int IN_TW     = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W     = VALUE_BITS + CNT_BITS,
	localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [VALUE_BITS-1:0] cfg_data,    // default_value
	// input beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TW-1:0]      s_tdata,     // key_begin, key_end, range_value, zero pad
	input  logic [1:0]            s_tuser,     // operation
	// result beats
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_TW-1:0]     m_tdata,     // read_value, entry_count, zero pad
	output logic [1:0]            m_tuser      // status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DEL,
		S_INS,
		S_OUT
	} state_t;

	state_t state_q;

	// beat fields held while the beat is worked
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   kb_q;
	logic [KEY_BITS-1:0]   ke_q;
	logic [VALUE_BITS-1:0] rv_q;

	logic [VALUE_BITS-1:0] default_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic [1:0]            st_q;
	logic                  ins_kb_q;   // begin breakpoint still to insert
	logic                  ins_ke_q;   // end breakpoint still to insert
	logic [VALUE_BITS-1:0] endv_q;

	// cell row
	logic [KEY_BITS-1:0]      ck   [CAPACITY];
	logic [VALUE_BITS-1:0]    cv   [CAPACITY];
	imra_pkg::cell_flag_t     fl   [CAPACITY];
	imra_pkg::cell_cmd_t      cmd  [CAPACITY];
	logic                     live [CAPACITY];
	logic                     bprev[CAPACITY];
	logic [KEY_BITS-1:0]      ins_key;
	logic [VALUE_BITS-1:0]    ins_val;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]   lk, rk;
		logic [VALUE_BITS-1:0] lv, rv;
		if (i == 0) begin : g_head
			assign lk       = '0;
			assign lv       = '0;
			assign bprev[i] = 1'b0;
		end else begin : g_body
			assign lk       = ck[i-1];
			assign lv       = cv[i-1];
			assign bprev[i] = fl[i-1].below;
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rk = '0;
			assign rv = '0;
		end else begin : g_mid
			assign rk = ck[i+1];
			assign rv = cv[i+1];
		end
		assign live[i] = CNT_BITS'(i) < count_q;

		imra_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.live     (live[i]),
			.cmd      (cmd[i]),
			.kb       (kb_q),
			.ke       (ke_q),
			.left_key (lk),
			.left_val (lv),
			.right_key(rk),
			.right_val(rv),
			.ins_key  (ins_key),
			.ins_val  (ins_val),
			.key      (ck[i]),
			.val      (cv[i]),
			.flags    (fl[i])
		);
	end

	// last-at-or-below selects: one-hot over the sorted row
	logic [VALUE_BITS-1:0] look_val, end_val, prev_val;
	logic                  prev_found, any_del, two_del;

	always_comb begin
		look_val   = '0;
		end_val    = '0;
		prev_val   = '0;
		prev_found = 1'b0;
		any_del    = 1'b0;
		two_del    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			logic nb, nl, ne, nd;
			nb = (i < CAPACITY - 1) ? fl[(i + 1) % CAPACITY].below   : 1'b0;
			nl = (i < CAPACITY - 1) ? fl[(i + 1) % CAPACITY].le_kb   : 1'b0;
			ne = (i < CAPACITY - 1) ? fl[(i + 1) % CAPACITY].le_ke   : 1'b0;
			nd = (i < CAPACITY - 1) ? fl[(i + 1) % CAPACITY].in_span : 1'b0;
			if (fl[i].le_kb && !nl) look_val = look_val | cv[i];
			if (fl[i].le_ke && !ne) end_val  = end_val  | cv[i];
			if (fl[i].below && !nb) begin
				prev_val   = prev_val | cv[i];
				prev_found = 1'b1;
			end
			any_del = any_del | fl[i].in_span;
			two_del = two_del | (fl[i].in_span && nd);
		end
	end

	// begin/end breakpoints needed and the capacity check
	logic              need_kb, need_ke, full;
	logic [CNT_BITS:0] grown, limit;

	always_comb begin
		need_kb = !prev_found || (prev_val != rv_q);
		need_ke = end_val != rv_q;
		grown   = {1'b0, count_q} + (CNT_BITS + 1)'(need_kb) + (CNT_BITS + 1)'(need_ke);
		limit   = (CNT_BITS + 1)'(CAPACITY) + (CNT_BITS + 1)'(any_del)
			+ (CNT_BITS + 1)'(two_del);
		full    = grown > limit;
	end

	// per-cell commands
	always_comb begin
		ins_key = ins_ke_q ? ke_q : kb_q;
		ins_val = ins_ke_q ? endv_q : rv_q;
		if (state_q == S_EVAL && op_q == imra_pkg::OP_CLEAR) begin
			ins_key = '0;
			ins_val = default_q;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			cmd[i] = imra_pkg::CELL_HOLD;
			unique case (state_q)
				S_EVAL: begin
					if (op_q == imra_pkg::OP_CLEAR && i == 0) cmd[i] = imra_pkg::CELL_LOAD;
				end
				S_DEL: begin
					// close the gap over covered breakpoints
					if (any_del && !fl[i].below) cmd[i] = imra_pkg::CELL_SHL;
				end
				S_INS: begin
					// open a slot at the first cell not below key_begin
					if ((ins_ke_q || ins_kb_q) && !fl[i].below)
						cmd[i] = (i == 0 || bprev[i]) ? imra_pkg::CELL_LOAD : imra_pkg::CELL_SHR;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = state_q == S_IDLE;
	assign m_tvalid  = state_q == S_OUT;
	assign m_tdata   = OUT_TW'({count_q, rd_q});
	assign m_tuser   = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			default_q <= '0;
			count_q   <= CNT_BITS'(1);
			ins_kb_q  <= 1'b0;
			ins_ke_q  <= 1'b0;
			st_q      <= imra_pkg::ST_DONE;
			rd_q      <= '0;
			op_q      <= imra_pkg::OP_ASSIGN;
			kb_q      <= '0;
			ke_q      <= '0;
			rv_q      <= '0;
			endv_q    <= '0;
		end else begin
			if (cfg_valid) default_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						kb_q    <= s_tdata[KEY_BITS-1:0];
						ke_q    <= s_tdata[2*KEY_BITS-1:KEY_BITS];
						rv_q    <= s_tdata[IN_W-1:2*KEY_BITS];
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					rd_q    <= '0;
					st_q    <= imra_pkg::ST_DONE;
					state_q <= S_OUT;
					unique case (op_q)
						imra_pkg::OP_LOOKUP: rd_q <= look_val;
						imra_pkg::OP_CLEAR:  count_q <= CNT_BITS'(1);
						imra_pkg::OP_ASSIGN: begin
							if (kb_q >= ke_q) begin
								st_q <= imra_pkg::ST_EMPTY;
							end else if (full) begin
								st_q <= imra_pkg::ST_FULL;
							end else begin
								ins_kb_q <= need_kb;
								ins_ke_q <= need_ke;
								endv_q   <= end_val;
								state_q  <= S_DEL;
							end
						end
						default: begin
						end
					endcase
				end
				S_DEL: begin
					if (any_del) count_q <= count_q - CNT_BITS'(1);
					else state_q <= S_INS;
				end
				S_INS: begin
					// end breakpoint goes in first, the begin one lands in front of it
					if (ins_ke_q) begin
						ins_ke_q <= 1'b0;
						count_q  <= count_q + CNT_BITS'(1);
					end else if (ins_kb_q) begin
						ins_kb_q <= 1'b0;
						count_q  <= count_q + CNT_BITS'(1);
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/imra_checker.sv =====
`include "assert_macros.svh"

module imra_checker #(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 8,
	localparam int CNT_BITS  = $clog2(CAPACITY + 1),
	localparam int OUT_W     = VALUE_BITS + CNT_BITS,
	localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata,
	input logic [1:0]        m_tuser
);

	logic [CNT_BITS-1:0] cnt;
	assign cnt = m_tdata[VALUE_BITS +: CNT_BITS];

	// a stalled result stays offered
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// no new beat taken while a result waits
	`ASSERT_IMPLIES(a_one_at_a_time, clk, arst_n, m_tvalid, !s_tready)
	// a taken input beat closes the input until its result is out
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// status code never the unused one
	`ASSERT_IMPLIES(a_status, clk, arst_n, m_tvalid, m_tuser != 2'd3)
	// table always holds between one and CAPACITY breakpoints
	`ASSERT_IMPLIES(a_count, clk, arst_n, m_tvalid, cnt != '0 && cnt <= CNT_BITS'(CAPACITY))

endmodule

bind interval_map_range_assign_unit imra_checker #(
	.CAPACITY  (CAPACITY),
	.KEY_BITS  (KEY_BITS),
	.VALUE_BITS(VALUE_BITS)
) u_imra_checker (.*);
